>>> rtl/lidar_packet_framer_macros.svh
// Assertion macros used by the checker file lpf_checker.sv.
`ifndef LIDAR_PACKET_FRAMER_MACROS_SVH
`define LIDAR_PACKET_FRAMER_MACROS_SVH

// Check cons in the same cycle as ante.
`define LPF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lidar_packet_framer check failed");

// Check cons in the cycle after ante.
`define LPF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lidar_packet_framer check failed");

`endif

>>> rtl/lpf_pkg.sv
package lpf_pkg;

	localparam int FRAME_BYTES = 22;
	localparam int DATA_BYTES  = FRAME_BYTES - 2;
	localparam int DATA_WORDS  = (DATA_BYTES + 1) / 2;
	localparam int SUM_W       = 16 + DATA_WORDS;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [7:0]  SYNC_RESET = 8'hFA;
	localparam int          FOLD_SHIFT = 15;
	localparam logic [14:0] FOLD_MASK  = 15'h7FFF;

	// Window, oldest byte at index 0.
	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} lpf_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} lpf_qstat_t;

	// Weighted sum of the little-endian data words, folded once to 15 bits.
	function automatic logic [14:0] folded_checksum(input frame_t f);
		logic [SUM_W-1:0] sum;
		logic [SUM_W-1:0] word;
		logic [SUM_W-1:0] fold;
		sum = '0;
		for (int k = 0; k < DATA_WORDS; k++) begin
			word = SUM_W'(f[2*k]);
			if (2*k + 1 < DATA_BYTES) begin
				word = word | (SUM_W'(f[2*k+1]) << 8);
			end
			sum = sum + (word << (DATA_WORDS - 1 - k));
		end
		fold = SUM_W'(sum[FOLD_SHIFT-1:0] & FOLD_MASK) + (sum >> FOLD_SHIFT);
		return fold[14:0];
	endfunction

endpackage

>>> rtl/lpf_rx_if.sv
interface lpf_rx_if import lpf_pkg::*;;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/lpf_frame_if.sv
interface lpf_frame_if import lpf_pkg::*;;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [4:0] byte_index;
	logic       last;

	modport source (output valid, output frame_byte, output byte_index, output last,
		input ready);
	modport sink (input valid, input frame_byte, input byte_index, input last,
		output ready);
endinterface

>>> rtl/lpf_cfg_if.sv
interface lpf_cfg_if import lpf_pkg::*;;
	logic       valid;
	logic       ready;
	logic [7:0] sync_byte;

	modport source (output valid, output sync_byte, input ready);
	modport sink (input valid, input sync_byte, output ready);
endinterface

>>> rtl/lpf_front.sv
module lpf_front import lpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lpf_rx_if.sink     rx,
	input  logic [7:0] sync_byte,
	input  lpf_qstat_t qstat,
	output lpf_push_t  push
);

	frame_t      window_q;
	logic        pend_q;
	logic        match;
	logic        stall;
	logic        accept;
	logic [15:0] received;

	// Test the window left by the last shift-in
	always_comb begin
		received = {window_q[FRAME_BYTES-1], window_q[FRAME_BYTES-2]};
		match = (window_q[0] == sync_byte) && !received[15] &&
			(received[14:0] == folded_checksum(window_q));
	end

	// Hold the window while a good frame waits for queue space
	assign stall    = pend_q && match && qstat.full;
	assign rx.ready = !stall;
	assign accept   = rx.valid && rx.ready;

	assign push.valid = pend_q && match && !qstat.full;
	assign push.frame = window_q;

	// Shift the new item in at the newest end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (accept) begin
			window_q <= {rx.rx_byte, window_q[FRAME_BYTES-1:1]};
		end
	end

	// Mark the window for testing in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (!stall) begin
			pend_q <= accept;
		end
	end

endmodule

>>> rtl/lpf_queue.sv
module lpf_queue import lpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lpf_push_t  push,
	input  logic       pop,
	output lpf_qstat_t qstat,
	output frame_t     head
);

	frame_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_ptr_q];

	// Store the pushed frame
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.frame;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push.valid) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/lpf_back.sv
module lpf_back import lpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lpf_qstat_t qstat,
	input  frame_t     head,
	output logic       pop,
	lpf_frame_if.source frame
);

	logic [IDX_W-1:0] idx_q;
	logic             is_last;
	logic             fire;

	// Present the head frame one byte at a time
	assign is_last          = (idx_q == IDX_W'(FRAME_BYTES - 1));
	assign frame.valid      = !qstat.empty;
	assign frame.frame_byte = head[idx_q];
	assign frame.byte_index = 5'(idx_q);
	assign frame.last       = is_last;

	assign fire = frame.valid && frame.ready;
	assign pop  = fire && is_last;

	// Step through the frame, wrap at its end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= is_last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

>>> rtl/lidar_packet_framer.sv
// Lidar packet framer.
// rx carries one received byte per item; rx.ready drops only while a good
// frame waits for room in the two-frame queue. Each accepted byte shifts into
// a 22-byte window; the next cycle tests that window (sync byte at the oldest
// end, folded 15-bit checksum against the last two bytes) in one adder tree.
// A passing frame goes into the queue and leaves on frame as 22 items,
// oldest byte first, byte_index 0..21, last set on the final one.
// cfg writes sync_byte; cfg.ready is always high. The first byte of a frame
// is offered once the window register and then the queue have captured it.
// Throughput: one item per cycle in and out while neither side stalls; rx
// stalls only when frames pass faster than frame drains them.
// When the receiver stalls, the current output item holds until taken.
// Reset clears the window to zeros, empties the queue and sets sync_byte
// to 0xFA.
module lidar_packet_framer import lpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	lpf_rx_if.sink      rx,
	lpf_cfg_if.sink     cfg,
	lpf_frame_if.source frame
);

	logic [7:0] sync_q;
	lpf_push_t  push;
	lpf_qstat_t qstat;
	frame_t     head;
	logic       pop;

	// Hold the sync register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg.valid && cfg.ready) begin
			sync_q <= cfg.sync_byte;
		end
	end

	lpf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.sync_byte (sync_q),
		.qstat     (qstat),
		.push      (push)
	);

	lpf_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	lpf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.frame  (frame)
	);

endmodule

>>> rtl/lpf_checker.sv
`include "lidar_packet_framer_macros.svh"

module lpf_checker import lpf_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       frame_valid,
	input logic       frame_ready,
	input logic [7:0] frame_byte,
	input logic [4:0] byte_index,
	input logic       last
);

	// A stalled output item holds
	`LPF_ASSERT_NEXT(a_out_hold, frame_valid && !frame_ready,
		frame_valid && $stable(frame_byte) && $stable(byte_index) && $stable(last))

	// last marks exactly the final position
	`LPF_ASSERT_NOW(a_last_pos, frame_valid, last == (byte_index == 5'(FRAME_BYTES - 1)))

	// Within a run the index advances by one
	`LPF_ASSERT_NEXT(a_idx_step, frame_valid && frame_ready && !last,
		frame_valid && (byte_index == $past(byte_index) + 5'd1))

	// A new run starts at index zero
	`LPF_ASSERT_NEXT(a_run_start, frame_valid && frame_ready && last,
		!frame_valid || (byte_index == 5'd0))

endmodule

bind lidar_packet_framer lpf_checker u_lpf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.frame_valid (frame.valid),
	.frame_ready (frame.ready),
	.frame_byte  (frame.frame_byte),
	.byte_index  (frame.byte_index),
	.last        (frame.last)
);
